FILE: rtl/core/twrm_pkg.sv
package twrm_pkg;

  // default sizes
  localparam int LONG_WINDOW_DEF   = 60;
  localparam int HISTORY_SLOTS_DEF = 1440;

  // arithmetic constants
  localparam int         SEC_PER_MIN = 60;
  localparam logic [7:0] RATE_MAX    = 8'd255;

  // item codes
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // register indexes
  localparam logic [1:0] CFG_SHORT_WINDOW     = 2'd0;
  localparam logic [1:0] CFG_CHARS_PER_WORD   = 2'd1;
  localparam logic [1:0] CFG_SECONDS_PER_SLOT = 2'd2;

  // register reset values
  localparam logic [5:0] SHORT_WINDOW_RST     = 6'd25;
  localparam logic [3:0] CHARS_PER_WORD_RST   = 4'd5;
  localparam logic [7:0] SECONDS_PER_SLOT_RST = 8'd60;

  typedef struct packed {
    logic mode;
    logic key_counts;
  } in_t;

  typedef struct packed {
    logic [7:0] rate_short;
    logic [7:0] rate_long;
    logic [7:0] rate_peak;
  } out_t;

  typedef struct packed {
    logic [5:0] short_window;
    logic [3:0] chars_per_word;
    logic [7:0] seconds_per_slot;
  } cfg_t;

  // queue head toward the back end
  typedef struct packed {
    logic valid;
    in_t  beat;
  } q_t;

  // back end control toward the front end
  typedef struct packed {
    logic pop;
    logic hold;
  } ctl_t;

endpackage

FILE: rtl/core/typing_rate_window_meter.sv
// channel  dir  ports                              beat
// input    in   in_valid, in_ready, in_data        mode, key_counts
// result   out  out_valid, out_ready, out_data     rate_short, rate_long, rate_peak
// config   in   cfg_we, cfg_index, cfg_wdata       one register per write
//
// a key event goes straight to the output state; a tick walks the ring and runs the divider for
// each rate, and also scans the store when the reused slot held the peak (store scan, one
// read a cycle); NW is the divider width, 20 at default size
// after reset a clearing pass zeroes every slot of the peak store with
// in_ready low; config writes are taken throughout
// a two-beat queue takes input while the back end works or the result stalls
module typing_rate_window_meter #(
  parameter int LONG_WINDOW   = twrm_pkg::LONG_WINDOW_DEF,
  parameter int HISTORY_SLOTS = twrm_pkg::HISTORY_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  twrm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output twrm_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_wdata
);
  import twrm_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  q_t   q;
  ctl_t ctl;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_WINDOW:     cfg_nxt.short_window     = cfg_wdata[5:0];
        CFG_CHARS_PER_WORD:   cfg_nxt.chars_per_word   = cfg_wdata[3:0];
        CFG_SECONDS_PER_SLOT: cfg_nxt.seconds_per_slot = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_window     <= SHORT_WINDOW_RST;
      cfg_r.chars_per_word   <= CHARS_PER_WORD_RST;
      cfg_r.seconds_per_slot <= SECONDS_PER_SLOT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  twrm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ctl      (ctl),
    .q        (q)
  );

  twrm_back #(
    .LONG_WINDOW   (LONG_WINDOW),
    .HISTORY_SLOTS (HISTORY_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q         (q),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/twrm_front.sv
module twrm_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  twrm_pkg::in_t   in_data,
  input  twrm_pkg::ctl_t  ctl,
  output twrm_pkg::q_t    q
);
  import twrm_pkg::*;

  in_t        buf_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  // accept unless full or the back end is clearing its store
  assign in_ready = (cnt_r != 2'd2) && !ctl.hold;
  assign push     = in_valid && in_ready;
  assign pop      = ctl.pop && (cnt_r != 2'd0);

  assign q.valid = (cnt_r != 2'd0);
  assign q.beat  = buf_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_data;
    end
  end

endmodule

FILE: rtl/core/twrm_div.sv
module twrm_div #(
  parameter int NW = 22,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   den_r, den_nxt;
  logic [NW-1:0]   quo_r, quo_nxt;
  logic [DW:0]     trial;

  assign done = done_r;
  assign quo  = quo_r;

  // one restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DW'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

endmodule

FILE: rtl/core/twrm_back.sv
module twrm_back #(
  parameter int LONG_WINDOW   = 60,
  parameter int HISTORY_SLOTS = 1440
) (
  input  logic            clk,
  input  logic            rst_n,
  input  twrm_pkg::cfg_t  cfg,
  input  twrm_pkg::q_t    q,
  output twrm_pkg::ctl_t  ctl,
  output logic            out_valid,
  input  logic            out_ready,
  output twrm_pkg::out_t  out_data
);
  import twrm_pkg::*;

  localparam int FW   = $clog2(LONG_WINDOW + 1);
  localparam int IW   = $clog2(LONG_WINDOW);
  localparam int CW   = (FW > 6) ? FW : 6;
  localparam int SUMW = $clog2(255 * LONG_WINDOW + 1);
  localparam int NW   = $clog2(255 * LONG_WINDOW * SEC_PER_MIN + LONG_WINDOW * 8 + 1);
  localparam int DW   = $clog2(LONG_WINDOW * 15 + 1);
  localparam int SAW  = $clog2(HISTORY_SLOTS);
  localparam int HCW  = $clog2(HISTORY_SLOTS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADV_RD, S_ADV_CHK, S_MAX, S_RING, S_SUM,
    S_DIV, S_DWAIT, S_PK_RD, S_PK_CHK, S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [HCW-1:0]  cnt_r, cnt_nxt;
  logic            vld_r, vld_nxt;
  logic [7:0]      sec_pr_r, sec_pr_nxt;
  logic [IW-1:0]   press_pos_r, press_pos_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [7:0]      stc_r, stc_nxt;
  logic            ticks_r, ticks_nxt;
  logic [SAW-1:0]  slot_pos_r, slot_pos_nxt;
  logic [7:0]      rs_r, rs_nxt;
  logic [7:0]      rl_r, rl_nxt;
  logic [7:0]      peak_r, peak_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [FW-1:0]   iss_r, iss_nxt;
  logic [FW-1:0]   con_r, con_nxt;
  logic [SUMW-1:0] sum_s_r, sum_s_nxt;
  logic [SUMW-1:0] sum_l_r, sum_l_nxt;
  logic            sel_r, sel_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;

  // memories
  logic [7:0]      ring_mem [LONG_WINDOW];
  logic [7:0]      slot_mem [HISTORY_SLOTS];
  logic            ring_we;
  logic [IW-1:0]   ring_raddr;
  logic [7:0]      ring_rd_r;
  logic            slot_we;
  logic [SAW-1:0]  slot_waddr, slot_raddr;
  logic [7:0]      slot_wdata, slot_rd_r;

  // arithmetic helpers
  logic [IW-1:0]   idx_dec;
  logic [FW-1:0]   sec_s, sec;
  logic [SUMW-1:0] pres;
  logic [DW-1:0]   den;
  logic [NW-1:0]   num;
  logic            div_start, div_done;
  logic [NW-1:0]   div_quo;
  logic [7:0]      div_rate;
  logic [7:0]      stc_inc;

  twrm_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ctl.pop   = (state_r == S_IDLE) && q.valid;
  assign ctl.hold  = (state_r == S_CLR);

  // window sizes and the rate operands
  always_comb begin
    idx_dec  = (idx_r == '0) ? IW'(LONG_WINDOW - 1) : idx_r - 1'b1;
    sec_s    = (CW'(fill_r) < CW'(cfg.short_window)) ? fill_r : FW'(cfg.short_window);
    sec      = sel_r ? fill_r : sec_s;
    pres     = sel_r ? sum_l_r : sum_s_r;
    den      = DW'(sec) * DW'(cfg.chars_per_word);
    num      = NW'(pres) * NW'(SEC_PER_MIN) + NW'(den >> 1);
    div_rate = (div_quo > NW'(RATE_MAX)) ? RATE_MAX : div_quo[7:0];
    stc_inc  = stc_r + 8'd1;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    vld_nxt       = 1'b0;
    sec_pr_nxt    = sec_pr_r;
    press_pos_nxt = press_pos_r;
    fill_nxt      = fill_r;
    stc_nxt       = stc_r;
    ticks_nxt     = ticks_r;
    slot_pos_nxt  = slot_pos_r;
    rs_nxt        = rs_r;
    rl_nxt        = rl_r;
    peak_nxt      = peak_r;
    idx_nxt       = idx_r;
    iss_nxt       = iss_r;
    con_nxt       = con_r;
    sum_s_nxt     = sum_s_r;
    sum_l_nxt     = sum_l_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ring_we       = 1'b0;
    ring_raddr    = idx_dec;
    slot_we       = 1'b0;
    slot_waddr    = slot_pos_r;
    slot_wdata    = 8'd0;
    slot_raddr    = slot_pos_r;
    div_start     = 1'b0;

    case (state_r)
      // zero the peak store after reset
      S_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = cnt_r[SAW-1:0];
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == HCW'(HISTORY_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q.valid) begin
          if (q.beat.mode == MODE_KEY) begin
            if (q.beat.key_counts && (sec_pr_r != RATE_MAX)) begin
              sec_pr_nxt = sec_pr_r + 8'd1;
            end
            state_nxt = S_OUT;
          end else if (ticks_r && (stc_r == 8'd0)) begin
            slot_pos_nxt = (slot_pos_r == SAW'(HISTORY_SLOTS - 1)) ? '0
                                                                   : slot_pos_r + 1'b1;
            state_nxt    = S_ADV_RD;
          end else begin
            state_nxt = S_RING;
          end
        end
      end
      S_ADV_RD: begin
        state_nxt = S_ADV_CHK;
      end
      // reused slot: clear it, rescan when it held the peak
      S_ADV_CHK: begin
        slot_we = 1'b1;
        if (slot_rd_r == peak_r) begin
          peak_nxt  = 8'd0;
          cnt_nxt   = '0;
          state_nxt = S_MAX;
        end else begin
          state_nxt = S_RING;
        end
      end
      // pipelined max over the store
      S_MAX: begin
        slot_raddr = cnt_r[SAW-1:0];
        if (cnt_r < HCW'(HISTORY_SLOTS)) begin
          cnt_nxt = cnt_r + 1'b1;
          vld_nxt = 1'b1;
        end
        if (vld_r && (slot_rd_r > peak_r)) begin
          peak_nxt = slot_rd_r;
        end
        if ((cnt_r == HCW'(HISTORY_SLOTS)) && !vld_r) begin
          state_nxt = S_RING;
        end
      end
      // store the second and move the counters
      S_RING: begin
        ring_we       = 1'b1;
        sec_pr_nxt    = 8'd0;
        press_pos_nxt = (press_pos_r == IW'(LONG_WINDOW - 1)) ? '0 : press_pos_r + 1'b1;
        if (fill_r < FW'(LONG_WINDOW)) begin
          fill_nxt = fill_r + 1'b1;
        end
        stc_nxt = ((cfg.seconds_per_slot != 8'd0) && (stc_inc >= cfg.seconds_per_slot))
                  ? 8'd0 : stc_inc;
        ticks_nxt = 1'b1;
        idx_nxt   = press_pos_nxt;
        iss_nxt   = '0;
        con_nxt   = '0;
        sum_s_nxt = '0;
        sum_l_nxt = '0;
        sel_nxt   = 1'b0;
        state_nxt = S_SUM;
      end
      // walk back through the ring, both windows in one pass
      S_SUM: begin
        if (iss_r < fill_r) begin
          idx_nxt = idx_dec;
          iss_nxt = iss_r + 1'b1;
          vld_nxt = 1'b1;
        end
        if (vld_r) begin
          sum_l_nxt = sum_l_r + SUMW'(ring_rd_r);
          if (con_r < sec_s) begin
            sum_s_nxt = sum_s_r + SUMW'(ring_rd_r);
          end
          con_nxt = con_r + 1'b1;
        end
        if ((iss_r == fill_r) && !vld_r) begin
          state_nxt = S_DIV;
        end
      end
      // rate setup, degenerate windows skip the divider
      S_DIV: begin
        if ((sec == '0) || (cfg.chars_per_word == 4'd0)) begin
          if (sel_r) begin
            rl_nxt    = ((sec != '0) && (pres != '0)) ? RATE_MAX : 8'd0;
            state_nxt = S_PK_RD;
          end else begin
            rs_nxt  = ((sec != '0) && (pres != '0)) ? RATE_MAX : 8'd0;
            sel_nxt = 1'b1;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          if (sel_r) begin
            rl_nxt    = div_rate;
            state_nxt = S_PK_RD;
          end else begin
            rs_nxt    = div_rate;
            sel_nxt   = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_PK_RD: begin
        state_nxt = S_PK_CHK;
      end
      // raise the slot peak and the running peak
      S_PK_CHK: begin
        if ((CW'(fill_r) >= CW'(cfg.short_window)) && (rs_r > slot_rd_r)) begin
          slot_we    = 1'b1;
          slot_wdata = rs_r;
          if (rs_r > peak_r) begin
            peak_nxt = rs_r;
          end
        end
        state_nxt = S_OUT;
      end
      // hand the held rates to the output register
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.rate_short = rs_r;
          out_data_nxt.rate_long  = rl_r;
          out_data_nxt.rate_peak  = peak_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      vld_r       <= 1'b0;
      sec_pr_r    <= 8'd0;
      press_pos_r <= '0;
      fill_r      <= '0;
      stc_r       <= 8'd0;
      ticks_r     <= 1'b0;
      slot_pos_r  <= '0;
      rs_r        <= 8'd0;
      rl_r        <= 8'd0;
      peak_r      <= 8'd0;
      iss_r       <= '0;
      con_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      sec_pr_r    <= sec_pr_nxt;
      press_pos_r <= press_pos_nxt;
      fill_r      <= fill_nxt;
      stc_r       <= stc_nxt;
      ticks_r     <= ticks_nxt;
      slot_pos_r  <= slot_pos_nxt;
      rs_r        <= rs_nxt;
      rl_r        <= rl_nxt;
      peak_r      <= peak_nxt;
      iss_r       <= iss_nxt;
      con_r       <= con_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    sum_s_r    <= sum_s_nxt;
    sum_l_r    <= sum_l_nxt;
    out_data_r <= out_data_nxt;
  end

  // per-second ring
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[press_pos_r] <= sec_pr_r;
    end
    ring_rd_r <= ring_mem[ring_raddr];
  end

  // per-slot peak store
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_r <= slot_mem[slot_raddr];
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  import twrm_pkg::*;

  localparam int RING_LEN   = LONG_WINDOW_DEF;
  localparam int SLOT_COUNT = HISTORY_SLOTS_DEF;
  // longest tick: ring walk, two divisions and a full store scan
  localparam int SETTLE_CYCLES = SLOT_COUNT + 400;

  // rate predictor and store of expected rate beats
  class rate_scoreboard;
    logic [5:0] short_win;
    logic [3:0] chars_word;
    logic [7:0] secs_slot;
    logic [7:0] sec_count;
    logic [7:0] ring [RING_LEN];
    int unsigned ring_pos;
    int unsigned ring_fill;
    logic [7:0] slot_ticks;
    logic       any_tick;
    int unsigned slot_idx;
    logic [7:0] slot_max [SLOT_COUNT];
    out_t       held;
    out_t       expected_rates[$];
    int         mismatches;

    function new();
      short_win  = SHORT_WINDOW_RST;
      chars_word = CHARS_PER_WORD_RST;
      secs_slot  = SECONDS_PER_SLOT_RST;
      sec_count  = '0;
      foreach (ring[i]) ring[i] = '0;
      foreach (slot_max[i]) slot_max[i] = '0;
      ring_pos   = 0;
      ring_fill  = 0;
      slot_ticks = '0;
      any_tick   = 1'b0;
      slot_idx   = 0;
      held       = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_SHORT_WINDOW:     short_win  = val[5:0];
        CFG_CHARS_PER_WORD:   chars_word = val[3:0];
        CFG_SECONDS_PER_SLOT: secs_slot  = val;
        default: ;
      endcase
    endfunction

    // rounded words per minute over the newest window seconds
    function logic [7:0] wpm(int unsigned window);
      int unsigned secs, presses, idx, denom, r;
      secs = (ring_fill < window) ? ring_fill : window;
      presses = 0;
      idx = ring_pos;
      if (secs == 0) return '0;
      for (int i = 0; i < secs; i++) begin
        idx = (idx == 0) ? RING_LEN - 1 : idx - 1;
        presses += ring[idx];
      end
      denom = secs * chars_word;
      if (denom == 0) return (presses != 0) ? RATE_MAX : 8'd0;
      r = (presses * SEC_PER_MIN + denom / 2) / denom;
      return (r > 255) ? RATE_MAX : r[7:0];
    endfunction

    function void note_beat(in_t beat);
      logic [7:0] peak, rs, rl, m;
      logic       gone;
      if (beat.mode == MODE_KEY) begin
        if (beat.key_counts && sec_count != RATE_MAX) sec_count++;
      end else begin
        peak = held.rate_peak;
        // move to the next peak slot; rescan if it held the peak
        if (any_tick && slot_ticks == 0) begin
          slot_idx = (slot_idx + 1) % SLOT_COUNT;
          gone = (slot_max[slot_idx] == peak);
          slot_max[slot_idx] = '0;
          if (gone) begin
            m = '0;
            foreach (slot_max[i]) if (slot_max[i] > m) m = slot_max[i];
            peak = m;
          end
        end
        ring[ring_pos] = sec_count;
        sec_count = '0;
        ring_pos = (ring_pos + 1) % RING_LEN;
        if (ring_fill < RING_LEN) ring_fill++;
        slot_ticks = slot_ticks + 8'd1;
        if (secs_slot != 0 && slot_ticks >= secs_slot) slot_ticks = '0;
        any_tick = 1'b1;
        rs = wpm(short_win);
        rl = wpm(RING_LEN);
        if (ring_fill >= short_win && rs > slot_max[slot_idx]) begin
          slot_max[slot_idx] = rs;
          if (rs > peak) peak = rs;
        end
        held.rate_short = rs;
        held.rate_long  = rl;
        held.rate_peak  = peak;
      end
      expected_rates.push_back(held);
    endfunction

    function void check_beat(out_t got);
      out_t exp_beat;
      if (expected_rates.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        mismatches++;
        return;
      end
      exp_beat = expected_rates.pop_front();
      if (got.rate_short !== exp_beat.rate_short) begin
        $error("rate_short expected %0d actual %0d", exp_beat.rate_short, got.rate_short);
        mismatches++;
      end
      if (got.rate_long !== exp_beat.rate_long) begin
        $error("rate_long expected %0d actual %0d", exp_beat.rate_long, got.rate_long);
        mismatches++;
      end
      if (got.rate_peak !== exp_beat.rate_peak) begin
        $error("rate_peak expected %0d actual %0d", exp_beat.rate_peak, got.rate_peak);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_rates.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  rate_scoreboard sb;
  int burst_left;
  int stall_mode;
  int stall_count;

  typing_rate_window_meter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #6000000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side: check accepted beats, stall in changing patterns
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_beat(out_data);
    if (stall_count == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      stall_count <= $urandom_range(16, 96);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // send one beat; bursts of random length with random gaps between them
  task automatic send_beat(input in_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(beat);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_item(input logic mode, input logic counts);
    in_t beat;
    beat.mode = mode;
    beat.key_counts = counts;
    send_beat(beat);
  endtask

  // stop sending and wait until the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(input logic [7:0] sw, input logic [7:0] cpw,
                          input logic [7:0] sps);
    write_reg(CFG_SHORT_WINDOW, sw);
    write_reg(CFG_CHARS_PER_WORD, cpw);
    write_reg(CFG_SECONDS_PER_SLOT, sps);
  endtask

  // random typing: mostly counted presses, a tick now and then
  task automatic random_items(input int n, input int tick_odds);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, tick_odds) == 0)
        send_item(MODE_TICK, $urandom_range(0, 1));
      else
        send_item(MODE_KEY, $urandom_range(0, 5) != 0);
    end
  endtask

  initial begin
    sb = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    burst_left  = 0;
    stall_mode  = 0;
    stall_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, both key kinds, ticks with the ignored bit set
    send_item(MODE_KEY, 1'b0);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_KEY, 1'b1);
    send_item(MODE_KEY, 1'b1);
    send_item(MODE_KEY, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_TICK, 1'b0);
    drain();

    // smallest settings: slot advance every tick
    set_regs(8'd1, 8'd1, 8'd1);
    for (int i = 0; i < 6; i++) send_item(MODE_KEY, 1'b1);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b0);
    random_items(30, 3);
    // hold off until every result is back
    drain();
    random_items(30, 3);
    drain();

    // largest settings
    set_regs(8'd60, 8'd15, 8'd255);
    random_items(50, 2);
    drain();

    // zero registers: short rate off, saturating rate, counter wrap at 256
    set_regs(8'd0, 8'd0, 8'd0);
    random_items(40, 3);
    drain();

    // lowered slot length with the tick counter above it
    set_regs(8'd3, 8'd2, 8'd2);
    random_items(30, 2);
    drain();

    // random register values, full data width
    for (int p = 0; p < 3; p++) begin
      set_regs($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      random_items(30, $urandom_range(1, 4));
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
